// File: hw/rtl/ctopa_pkg.sv
// ----------------------------------------------------------------------------
// ctopa_pkg
// Shared widths, codes and types of the cell tensor outer product accumulator.
// ----------------------------------------------------------------------------
package ctopa_pkg;

  localparam int CELL_W    = 5;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int SEG_W     = 32;
  localparam int BURG_W    = 18;
  localparam int PROD_W    = SEG_W + BURG_W;
  localparam int OUT_W     = 48;
  localparam int NUM_ENT   = 9;
  // Wide enough for the largest linear index (31*31*30 + 31*30 + 30) and for 65536.
  localparam int LIN_W     = 17;

  localparam int DEF_MAX_CELLS = 4096;
  localparam int DEF_ACC_WIDTH = 48;

  localparam logic [CFG_W-1:0] RST_CELLS = 5'd4;

  localparam logic [CFG_IDX_W-1:0] REG_X_CELLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_CELLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Z_CELLS = 2'd2;

  localparam logic FUNC_ACC  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef struct packed {
    logic             ok;
    logic [LIN_W-1:0] lin;
  } cell_loc_t;

endpackage

// File: hw/rtl/ctopa_ram.sv
// ----------------------------------------------------------------------------
// ctopa_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module ctopa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/ctopa_cellidx.sv
// ----------------------------------------------------------------------------
// ctopa_cellidx
// Turns one-based cell indices into a linear cell index and checks bounds.
// ----------------------------------------------------------------------------
module ctopa_cellidx
  import ctopa_pkg::*;
#(
  parameter int MAX_CELLS = DEF_MAX_CELLS
) (
  input  logic [CELL_W-1:0] cell_x,
  input  logic [CELL_W-1:0] cell_y,
  input  logic [CELL_W-1:0] cell_z,
  input  logic [CFG_W-1:0]  x_cells,
  input  logic [CFG_W-1:0]  y_cells,
  input  logic [CFG_W-1:0]  z_cells,
  output cell_loc_t         loc
);

  logic [2*CFG_W-1:0] zy;
  logic [LIN_W-1:0]   lin;
  logic               in_grid;

  always_comb begin
    zy  = (2*CFG_W)'(z_cells) * (2*CFG_W)'(y_cells);
    lin = LIN_W'(cell_z - 1'b1)
        + LIN_W'(z_cells) * LIN_W'(cell_y - 1'b1)
        + LIN_W'(zy) * LIN_W'(cell_x - 1'b1);
    in_grid = (cell_x != '0) && (cell_y != '0) && (cell_z != '0)
           && (cell_x <= x_cells) && (cell_y <= y_cells) && (cell_z <= z_cells);
    loc.ok  = in_grid && (lin < LIN_W'(MAX_CELLS));
    loc.lin = lin;
  end

endmodule

// File: hw/rtl/ctopa_lane.sv
// ----------------------------------------------------------------------------
// ctopa_lane
// Saturating add of one outer product term into one tensor entry.
// ----------------------------------------------------------------------------
module ctopa_lane
  import ctopa_pkg::*;
#(
  parameter int ACC_WIDTH = DEF_ACC_WIDTH
) (
  input  logic signed [PROD_W-1:0]    prod,
  input  logic signed [ACC_WIDTH-1:0] acc,
  output logic signed [ACC_WIDTH-1:0] sum
);

  localparam int SW = ((ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W) + 1;

  logic signed [SW-1:0]   full;
  logic [SW-ACC_WIDTH:0]  top;
  logic                   ovf;

  always_comb begin
    full = SW'(acc) + SW'(prod);
    top  = full[SW-1:ACC_WIDTH-1];
    // In range only when every bit above the result sign matches it.
    ovf  = !((&top) || !(|top));
    if (ovf) begin
      sum = full[SW-1] ? {1'b1, {(ACC_WIDTH-1){1'b0}}} : {1'b0, {(ACC_WIDTH-1){1'b1}}};
    end else begin
      sum = full[ACC_WIDTH-1:0];
    end
  end

endmodule

// File: hw/rtl/cell_tensor_outer_product_accumulator_core.sv
// A read item's result is loaded into the output register in the modify state, once
// that register is free. A new item is accepted only after the last item's read-modify-write of
// one tensor row in the single-port-write memory (address, read, write back) ends.
// Reset: cell counts return to 4 and a clearing pass writes zero to all MAX_CELLS
// rows, one row a cycle, during which no item is accepted.
// ----------------------------------------------------------------------------
// cell_tensor_outer_product_accumulator_core
// Per-cell 3x3 charge tensor store with saturating outer product accumulation
// and read-and-clear of a cell's tensor.
// ----------------------------------------------------------------------------
module cell_tensor_outer_product_accumulator_core
  import ctopa_pkg::*;
#(
  parameter int MAX_CELLS = DEF_MAX_CELLS,
  parameter int ACC_WIDTH = DEF_ACC_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_addr,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_func,
  input  logic [CELL_W-1:0]        in_cell_x,
  input  logic [CELL_W-1:0]        in_cell_y,
  input  logic [CELL_W-1:0]        in_cell_z,
  input  logic signed [SEG_W-1:0]  in_seg_dx,
  input  logic signed [SEG_W-1:0]  in_seg_dy,
  input  logic signed [SEG_W-1:0]  in_seg_dz,
  input  logic signed [BURG_W-1:0] in_burg_x,
  input  logic signed [BURG_W-1:0] in_burg_y,
  input  logic signed [BURG_W-1:0] in_burg_z,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [OUT_W-1:0]  out_t_xx,
  output logic signed [OUT_W-1:0]  out_t_xy,
  output logic signed [OUT_W-1:0]  out_t_xz,
  output logic signed [OUT_W-1:0]  out_t_yx,
  output logic signed [OUT_W-1:0]  out_t_yy,
  output logic signed [OUT_W-1:0]  out_t_yz,
  output logic signed [OUT_W-1:0]  out_t_zx,
  output logic signed [OUT_W-1:0]  out_t_zy,
  output logic signed [OUT_W-1:0]  out_t_zz
);

  localparam int AW    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int ROW_W = NUM_ENT * ACC_WIDTH;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_MOD  = 2'd2;

  // Configuration registers.
  logic [CFG_W-1:0] x_cells_r, y_cells_r, z_cells_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_cells_r <= RST_CELLS;
      y_cells_r <= RST_CELLS;
      z_cells_r <= RST_CELLS;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_X_CELLS: x_cells_r <= cfg_wdata;
        REG_Y_CELLS: y_cells_r <= cfg_wdata;
        REG_Z_CELLS: z_cells_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Control state.
  logic [1:0]    st_r, st_nxt;
  logic          clr_busy_r, clr_busy_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Item registers (payload, no reset).
  logic                     func_r;
  logic                     ok_r;
  logic [AW-1:0]            addr_r;
  logic signed [PROD_W-1:0] prod_r [NUM_ENT];
  logic signed [OUT_W-1:0]  out_r  [NUM_ENT];

  cell_loc_t                loc;
  logic signed [SEG_W-1:0]  seg  [3];
  logic signed [BURG_W-1:0] burg [3];
  logic                     in_acc;
  logic                     out_free;
  logic                     load_out;

  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [ROW_W-1:0]         mem_wdata;
  logic [ROW_W-1:0]         mem_rdata;
  logic signed [ACC_WIDTH-1:0] old_ent [NUM_ENT];
  logic signed [ACC_WIDTH-1:0] new_ent [NUM_ENT];
  logic [ROW_W-1:0]         sum_row;

  ctopa_cellidx #(
    .MAX_CELLS (MAX_CELLS)
  ) u_cellidx (
    .cell_x  (in_cell_x),
    .cell_y  (in_cell_y),
    .cell_z  (in_cell_z),
    .x_cells (x_cells_r),
    .y_cells (y_cells_r),
    .z_cells (z_cells_r),
    .loc     (loc)
  );

  ctopa_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (st_r == ST_RD),
    .raddr (addr_r),
    .rdata (mem_rdata)
  );

  for (genvar k = 0; k < NUM_ENT; k++) begin : g_lane
    assign old_ent[k] = mem_rdata[k*ACC_WIDTH +: ACC_WIDTH];
    ctopa_lane #(
      .ACC_WIDTH (ACC_WIDTH)
    ) u_lane (
      .prod (prod_r[k]),
      .acc  (old_ent[k]),
      .sum  (new_ent[k])
    );
    assign sum_row[k*ACC_WIDTH +: ACC_WIDTH] = new_ent[k];
  end

  assign seg[0]  = in_seg_dx;
  assign seg[1]  = in_seg_dy;
  assign seg[2]  = in_seg_dz;
  assign burg[0] = in_burg_x;
  assign burg[1] = in_burg_y;
  assign burg[2] = in_burg_z;

  assign in_ready = (st_r == ST_IDLE) && !clr_busy_r;
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  // A read item waits in the modify state until the output register is free.
  assign load_out = (st_r == ST_MOD) && (func_r == FUNC_READ) && out_free;

  always_comb begin
    st_nxt       = st_r;
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    mem_we       = 1'b0;
    mem_waddr    = addr_r;
    mem_wdata    = sum_row;
    if (clr_busy_r) begin
      mem_we       = 1'b1;
      mem_waddr    = clr_addr_r;
      mem_wdata    = '0;
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(MAX_CELLS - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          st_nxt = ST_RD;
        end
      end
      ST_RD: begin
        st_nxt = ST_MOD;
      end
      ST_MOD: begin
        if (func_r == FUNC_ACC) begin
          mem_we = ok_r;
          st_nxt = ST_IDLE;
        end else if (out_free) begin
          mem_we    = ok_r;
          mem_wdata = '0;
          st_nxt    = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_busy_r  <= clr_busy_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_func;
      ok_r   <= loc.ok;
      addr_r <= loc.lin[AW-1:0];
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_r[i*3+j] <= PROD_W'(burg[i]) * PROD_W'(seg[j]);
        end
      end
    end
    if (load_out) begin
      for (int k = 0; k < NUM_ENT; k++) begin
        out_r[k] <= ok_r ? OUT_W'(old_ent[k]) : '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_t_xx  = out_r[0];
  assign out_t_xy  = out_r[1];
  assign out_t_xz  = out_r[2];
  assign out_t_yx  = out_r[3];
  assign out_t_yy  = out_r[4];
  assign out_t_yz  = out_r[5];
  assign out_t_zx  = out_r[6];
  assign out_t_zy  = out_r[7];
  assign out_t_zz  = out_r[8];

`ifndef SYNTHESIS
  a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_ready)
    else $error("item accepted during the clearing pass");

  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (clr_busy_r || st_r == ST_MOD))
    else $error("memory written outside clearing or modify");

  a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(st_r) == ST_MOD && $past(func_r) == FUNC_READ))
    else $error("result produced without a read item");

  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RD) |=> (st_r == ST_MOD))
    else $error("read stage not followed by modify stage");
`endif

endmodule
